// ===== src/u8u2_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder package
// Shared widths and byte masks for the stream decoder and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u2_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 16;
    localparam int NEED_W = 2;

    // Payload bits carried by each byte form
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h7f;
    localparam logic [BYTE_W-1:0] LEAD_MASK  = 8'h1f;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3f;

    // Continuation bytes still expected after a lead byte
    localparam logic [NEED_W-1:0] NEED_NONE = 2'd0;
    localparam logic [NEED_W-1:0] NEED_ONE  = 2'd1;
    localparam logic [NEED_W-1:0] NEED_TWO  = 2'd2;

endpackage : u8u2_pkg

`default_nettype wire

// ===== src/utf8_to_ucs2_stream_decoder_core.sv =====
// A result beat is registered and shown in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the output stalls; the output register
// frees in the same cycle its beat is taken, so input and output run back to back.
// Reset (rst_n low, asynchronous): decode state cleared, output register empty.
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 stream decoder
// Decodes one UTF-8 byte per beat into 16-bit code points; tlast on the input
// marks the final byte, which always yields one result with tlast set.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_ucs2_stream_decoder_core
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // tdata: [7:0] in_byte
    input  wire logic [u8u2_pkg::BYTE_W-1:0] s_axis_tdata,
    input  wire logic                        s_axis_tlast,   // end_of_string
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: [15:0] code_point
    output logic [u8u2_pkg::CP_W-1:0]        m_axis_tdata,
    output logic                             m_axis_tuser,   // bad_encoding
    output logic                             m_axis_tlast,   // string_done
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready
);

    import u8u2_pkg::*;

    logic [NEED_W-1:0] bytes_still_needed_reg, bytes_still_needed_next;
    logic [CP_W-1:0]   partial_code_reg, partial_code_next;
    logic              string_failed_reg, string_failed_next;

    logic              out_valid_reg, out_valid_next;
    logic [CP_W-1:0]   out_code_reg;
    logic              out_bad_reg;
    logic              out_done_reg;

    logic              accept;
    logic              is_cont;
    logic              cp_done;
    logic [CP_W-1:0]   cp_value;
    logic              emit;
    logic [CP_W-1:0]   emit_code;
    logic              emit_bad;
    logic              bad;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_cont       = (s_axis_tdata[7:6] == 2'b10);

    always_comb
    begin
        bytes_still_needed_next = bytes_still_needed_reg;
        partial_code_next       = partial_code_reg;
        string_failed_next      = string_failed_reg;
        cp_done                 = 1'b0;
        cp_value                = '0;

        if (!string_failed_reg)
        begin
            if (bytes_still_needed_reg != NEED_NONE)
            begin
                if (is_cont)
                begin
                    partial_code_next = {partial_code_reg[CP_W-7:0],
                                         s_axis_tdata[5:0] & CONT_MASK[5:0]};
                    bytes_still_needed_next = bytes_still_needed_reg - NEED_ONE;
                    if (bytes_still_needed_reg == NEED_ONE)
                    begin
                        cp_done  = 1'b1;
                        cp_value = partial_code_next;
                    end
                end
                else
                begin
                    // break in the sequence: the byte is not decoded again
                    string_failed_next = 1'b1;
                end
            end
            else if (!s_axis_tdata[7])
            begin
                cp_done  = 1'b1;
                cp_value = {{(CP_W-BYTE_W){1'b0}}, s_axis_tdata & ASCII_MASK};
            end
            else if (s_axis_tdata[7:5] == 3'b110)
            begin
                partial_code_next       = {{(CP_W-BYTE_W){1'b0}}, s_axis_tdata & LEAD_MASK};
                bytes_still_needed_next = NEED_ONE;
            end
            else if (s_axis_tdata[7:4] == 4'b1110)
            begin
                partial_code_next       = {{(CP_W-BYTE_W){1'b0}}, s_axis_tdata & LEAD_MASK};
                bytes_still_needed_next = NEED_TWO;
            end
            else
            begin
                // stray continuation or four-plus leading ones
                string_failed_next = 1'b1;
            end
        end

        bad       = string_failed_next || (bytes_still_needed_next != NEED_NONE) || !cp_done;
        emit      = s_axis_tlast || cp_done;
        emit_bad  = s_axis_tlast && bad;
        emit_code = emit_bad ? '0 : cp_value;

        if (s_axis_tlast)
        begin
            // final byte: return to the idle decode state
            bytes_still_needed_next = NEED_NONE;
            partial_code_next       = '0;
            string_failed_next      = 1'b0;
        end

        if (accept)
            out_valid_next = emit;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_still_needed_reg <= NEED_NONE;
            partial_code_reg       <= '0;
            string_failed_reg      <= 1'b0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                bytes_still_needed_reg <= bytes_still_needed_next;
                partial_code_reg       <= partial_code_next;
                string_failed_reg      <= string_failed_next;
            end
        end
    end

    // hold the payload until a new beat replaces it
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_code_reg <= emit_code;
            out_bad_reg  <= emit_bad;
            out_done_reg <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_code_reg;
    assign m_axis_tuser  = out_bad_reg;
    assign m_axis_tlast  = out_done_reg;

endmodule : utf8_to_ucs2_stream_decoder_core

`default_nettype wire

// ===== src/u8u2_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder checker
// Port-level properties of the stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u2_checker
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_axis_tlast,
    input wire logic                        s_axis_tvalid,
    input wire logic                        s_axis_tready,
    input wire logic [u8u2_pkg::CP_W-1:0]   m_axis_tdata,
    input wire logic                        m_axis_tuser,
    input wire logic                        m_axis_tlast,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready
);

    import u8u2_pkg::*;

    // an error is reported only on the final beat of a string
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("error beat without string end");

    // an error beat carries a zero code point
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == {CP_W{1'b0}})
        else $error("error beat with non-zero code point");

    // a final input byte always produces a final result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
        else $error("final byte gave no final result");

    // an empty output register never stalls the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with output empty");

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

endmodule : u8u2_checker

bind utf8_to_ucs2_stream_decoder_core u8u2_checker u_checker (.*);

`default_nettype wire
